// File: src/rmo_pkg.sv
// ----------------------------------------------------------------------------
// rmo_pkg
// Shared types, fixed-point constants and pipeline latencies for the rotation
// matrix re-orthonormaliser.
// ----------------------------------------------------------------------------
package rmo_pkg;

  // Fraction bits of the Q2.30 format.
  localparam int FRAC = 30;

  // One result bit is produced per stage in the square root and in the
  // quotient pipelines.
  localparam int ROOT_STEPS = 31;
  localparam int QUOT_STEPS = 31;

  // Magnitude, leading-one search, shift, square, sum, root steps, dividend
  // set-up, quotient steps and sign restore.
  localparam int UNIT_LAT  = 5 + ROOT_STEPS + 1 + QUOT_STEPS + 1;
  localparam int CROSS_LAT = 2;

  // Five normalisation passes, four cross products, the sum and the rounding.
  localparam int TOTAL_LAT = 5 * UNIT_LAT + 4 * CROSS_LAT + 2;

  typedef logic [31:0]             q30_t;
  typedef logic [2:0][31:0]        vec3_t;
  typedef logic [2:0][33:0]        sumv_t;
  typedef logic [2:0][63:0]        wvec_t;
  typedef logic [2:0][2:0][31:0]   mat_t;

endpackage

// File: src/rmo_delay.sv
// ----------------------------------------------------------------------------
// rmo_delay
// Stallable delay line that keeps side data in step with the arithmetic.
// ----------------------------------------------------------------------------
module rmo_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < N; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

// File: src/rmo_cross.sv
// ----------------------------------------------------------------------------
// rmo_cross
// Exact cross product of two Q2.30 vectors, giving Q4.60 components.
// ----------------------------------------------------------------------------
module rmo_cross (
  input  logic          clk,
  input  logic          en,
  input  rmo_pkg::vec3_t a,
  input  rmo_pkg::vec3_t b,
  output rmo_pkg::wvec_t c
);

  logic signed [63:0] p [6];

  // First stage holds the six products, second stage the differences.
  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= $signed(a[1]) * $signed(b[2]);
      p[1] <= $signed(a[2]) * $signed(b[1]);
      p[2] <= $signed(a[2]) * $signed(b[0]);
      p[3] <= $signed(a[0]) * $signed(b[2]);
      p[4] <= $signed(a[0]) * $signed(b[1]);
      p[5] <= $signed(a[1]) * $signed(b[0]);
      c[0] <= p[0] - p[1];
      c[1] <= p[2] - p[3];
      c[2] <= p[4] - p[5];
    end
  end

endmodule

// File: src/rmo_unit.sv
// ----------------------------------------------------------------------------
// rmo_unit
// Pipelined vector normaliser: block scaling by powers of two, sum of squares,
// bit-per-stage integer square root and bit-per-stage rounded quotients.
// ----------------------------------------------------------------------------
module rmo_unit #(
  parameter int W = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2:0][W-1:0] v,
  output rmo_pkg::vec3_t  u,
  output logic            ok
);

  localparam int PW = $clog2(W);
  localparam int SN = rmo_pkg::ROOT_STEPS;
  localparam int DN = rmo_pkg::QUOT_STEPS;

  // Magnitudes and the OR of them; its top bit is that of the largest one.
  logic [2:0][W-1:0] magv;
  logic [2:0][W-1:0] mag1;
  logic [2:0]        sgn1;
  logic [W-1:0]      orw1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      magv[i] = v[i][W-1] ? (~v[i] + 1'b1) : v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn1[i] <= v[i][W-1];
      end
      mag1 <= magv;
      orw1 <= magv[0] | magv[1] | magv[2];
    end
  end

  // Leading-one position.
  logic [PW-1:0]     pos;
  logic [PW-1:0]     pos2;
  logic [2:0][W-1:0] mag2;
  logic [2:0]        sgn2;
  logic              nz2;

  always_comb begin
    pos = '0;
    for (int k = 0; k < W; k++) begin
      if (orw1[k]) begin
        pos = PW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos2 <= pos;
      mag2 <= mag1;
      sgn2 <= sgn1;
      nz2  <= |orw1;
    end
  end

  // Common shift that puts the largest magnitude in [2^29, 2^30).
  logic [PW-1:0]     rsh;
  logic [PW-1:0]     lsh;
  logic [2:0][29:0]  smv;
  logic [2:0][29:0]  sm3;
  logic [2:0]        sgn3;
  logic              nz3;

  always_comb begin
    rsh = pos2 - PW'(29);
    lsh = PW'(29) - pos2;
    for (int i = 0; i < 3; i++) begin
      if (pos2 >= PW'(29)) begin
        smv[i] = 30'(mag2[i] >> rsh);
      end else begin
        smv[i] = mag2[i][29:0] << lsh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm3  <= smv;
      sgn3 <= sgn2;
      nz3  <= nz2;
    end
  end

  // Squares.
  logic [2:0][59:0] sq4;
  logic [2:0][29:0] sm4;
  logic [2:0]       sgn4;
  logic             nz4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= sm3[i] * sm3[i];
      end
      sm4  <= sm3;
      sgn4 <= sgn3;
      nz4  <= nz3;
    end
  end

  // Square root pipeline; entry 0 is loaded with the sum of squares.
  logic [61:0]      sq_s    [SN+1];
  logic [31:0]      sq_rem  [SN+1];
  logic [30:0]      sq_root [SN+1];
  logic [2:0][29:0] sq_mag  [SN+1];
  logic [2:0]       sq_sgn  [SN+1];
  logic             sq_nz   [SN+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s[0]    <= 62'(sq4[0]) + 62'(sq4[1]) + 62'(sq4[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_mag[0]  <= sm4;
      sq_sgn[0]  <= sgn4;
      sq_nz[0]   <= nz4;
    end
  end

  for (genvar k = 0; k < SN; k++) begin : g_root
    logic [33:0] cur;
    logic [33:0] trial;
    logic        ge;

    always_comb begin
      cur   = {sq_rem[k], sq_s[k][61-2*k -: 2]};
      trial = {1'b0, sq_root[k], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k+1]  <= ge ? 32'(cur - trial) : cur[31:0];
        sq_root[k+1] <= {sq_root[k][29:0], ge};
        sq_s[k+1]    <= sq_s[k];
        sq_mag[k+1]  <= sq_mag[k];
        sq_sgn[k+1]  <= sq_sgn[k];
        sq_nz[k+1]   <= sq_nz[k];
      end
    end
  end

  // Quotient pipeline. The dividend is mag * 2^30 + floor(r/2); its upper
  // bits are already below r, so only the low 31 quotient bits remain.
  logic [2:0][60:0] nn;
  logic [2:0][60:0] dv_n   [DN+1];
  logic [2:0][31:0] dv_rem [DN+1];
  logic [2:0][30:0] dv_q   [DN+1];
  logic [30:0]      dv_r   [DN+1];
  logic [2:0]       dv_sgn [DN+1];
  logic             dv_nz  [DN+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nn[i] = {1'b0, sq_mag[SN][i], 30'b0} + 61'(sq_root[SN][30:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {2'b0, nn[i][60:31]};
      end
      dv_n[0]   <= nn;
      dv_q[0]   <= '0;
      dv_r[0]   <= sq_root[SN];
      dv_sgn[0] <= sq_sgn[SN];
      dv_nz[0]  <= sq_nz[SN];
    end
  end

  for (genvar j = 0; j < DN; j++) begin : g_quot
    logic [2:0][32:0] cur;
    logic [2:0]       ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cur[i] = {dv_rem[j][i], dv_n[j][i][30-j]};
        ge[i]  = cur[i] >= {2'b0, dv_r[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= ge[i] ? 32'(cur[i] - {2'b0, dv_r[j]}) : cur[i][31:0];
          dv_q[j+1][i]   <= {dv_q[j][i][29:0], ge[i]};
        end
        dv_n[j+1]   <= dv_n[j];
        dv_r[j+1]   <= dv_r[j];
        dv_sgn[j+1] <= dv_sgn[j];
        dv_nz[j+1]  <= dv_nz[j];
      end
    end
  end

  // Sign restore.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= dv_sgn[DN][i] ? (~{1'b0, dv_q[DN][i]} + 32'd1) : {1'b0, dv_q[DN][i]};
      end
      ok <= dv_nz[DN];
    end
  end

endmodule

// File: src/rotation_matrix_reorthonormalize_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_reorthonormalize_top
// Returns the orthonormal matrix nearest in spirit to a 3x3 Q2.30 rotation
// matrix, built from the averaged frames of the three cyclic row pairs.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tdata: nine Q2.30 entries, row 0 column 0 lowest
//  m_axis   | out       | tdata: nine Q2.30 entries; tuser: degenerate flag
//
// One item is accepted in every cycle in which the output register is free or
// being emptied. Each item passes 5 * 69 + 4 * 2 + 2 = 355 pipeline stages and
// the output register; the figure is set by the five normalisation passes in
// series, each with a 31-stage square root and a 31-stage quotient pipeline.
// Reset clears the valid bits, the output valid among them; data registers,
// including the output data, are not reset. When the output item is held,
// every stage freezes at once, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_reorthonormalize_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,   // in_r0c0, in_r0c1, ... in_r2c2 (32 bits each)
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,   // out_r0c0, out_r0c1, ... out_r2c2 (32 bits each)
  output logic [0:0]   m_axis_tuser    // degenerate
);

  localparam int U = rmo_pkg::UNIT_LAT;
  localparam int C = rmo_pkg::CROSS_LAT;
  localparam int L = rmo_pkg::TOTAL_LAT;

  // The whole pipeline advances together whenever the output register is
  // free or being emptied.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [L-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], s_axis_tvalid};
    end
  end

  rmo_pkg::mat_t min;
  assign min = rmo_pkg::mat_t'(s_axis_tdata);

  // Unit rows x, y and z.
  rmo_pkg::vec3_t x, y, z;
  logic okx, oky, okz;

  rmo_unit #(.W(32)) u_nx (.clk(clk), .en(en), .v(min[0]), .u(x), .ok(okx));
  rmo_unit #(.W(32)) u_ny (.clk(clk), .en(en), .v(min[1]), .u(y), .ok(oky));
  rmo_unit #(.W(32)) u_nz (.clk(clk), .en(en), .v(min[2]), .u(z), .ok(okz));

  // Third axis of each frame: unit(x cross y), unit(y cross z), unit(z cross x).
  rmo_pkg::wvec_t cxy, cyz, czx;

  rmo_cross u_cxy (.clk(clk), .en(en), .a(x), .b(y), .c(cxy));
  rmo_cross u_cyz (.clk(clk), .en(en), .a(y), .b(z), .c(cyz));
  rmo_cross u_czx (.clk(clk), .en(en), .a(z), .b(x), .c(czx));

  rmo_pkg::vec3_t a1, a2, a3;
  logic oka1, oka2, oka3;

  rmo_unit #(.W(64)) u_na1 (.clk(clk), .en(en), .v(cxy), .u(a1), .ok(oka1));
  rmo_unit #(.W(64)) u_na2 (.clk(clk), .en(en), .v(cyz), .u(a2), .ok(oka2));
  rmo_unit #(.W(64)) u_na3 (.clk(clk), .en(en), .v(czx), .u(a3), .ok(oka3));

  // Rows x, y, z held until the a vectors are ready.
  rmo_pkg::vec3_t xd, yd, zd;
  logic           ok1;

  rmo_delay #(.W(289), .N(U + C)) u_d1 (
    .clk(clk), .en(en),
    .d({okx & oky & okz, z, y, x}),
    .q({ok1, zd, yd, xd})
  );

  // Second axis of each frame: unit(a cross first row).
  rmo_pkg::wvec_t e1, e2, e3;

  rmo_cross u_e1 (.clk(clk), .en(en), .a(a1), .b(xd), .c(e1));
  rmo_cross u_e2 (.clk(clk), .en(en), .a(a2), .b(yd), .c(e2));
  rmo_cross u_e3 (.clk(clk), .en(en), .a(a3), .b(zd), .c(e3));

  rmo_pkg::vec3_t b1, b3;
  logic okb1, okb2, okb3;

  // The middle frame's second axis is a z row and is not summed; only its
  // zero-length check counts.
  rmo_unit #(.W(64)) u_nb1 (.clk(clk), .en(en), .v(e1), .u(b1), .ok(okb1));
  rmo_unit #(.W(64)) u_nb2 (.clk(clk), .en(en), .v(e2), .u(),   .ok(okb2));
  rmo_unit #(.W(64)) u_nb3 (.clk(clk), .en(en), .v(e3), .u(b3), .ok(okb3));

  rmo_pkg::vec3_t xd2, yd2, a2d, a3d;
  logic           ok2;

  rmo_delay #(.W(385), .N(U + C)) u_d2 (
    .clk(clk), .en(en),
    .d({ok1 & oka1 & oka2 & oka3, a3, a2, yd, xd}),
    .q({ok2, a3d, a2d, yd2, xd2})
  );

  // Sums of the x rows and of the y rows of the three frames.
  rmo_pkg::sumv_t sx, sy;
  logic           ok3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sx[i] <= {{2{xd2[i][31]}}, xd2[i]} + {{2{a2d[i][31]}}, a2d[i]}
               + {{2{b3[i][31]}}, b3[i]};
        sy[i] <= {{2{b1[i][31]}}, b1[i]} + {{2{yd2[i][31]}}, yd2[i]}
               + {{2{a3d[i][31]}}, a3d[i]};
      end
      ok3 <= ok2 & okb1 & okb2 & okb3;
    end
  end

  rmo_pkg::vec3_t xf, yf;
  logic okxf, okyf, ok3d;

  rmo_unit #(.W(34)) u_nxf (.clk(clk), .en(en), .v(sx), .u(xf), .ok(okxf));
  rmo_unit #(.W(34)) u_nyf (.clk(clk), .en(en), .v(sy), .u(yf), .ok(okyf));

  rmo_delay #(.W(1), .N(U)) u_d3 (.clk(clk), .en(en), .d(ok3), .q(ok3d));

  // Final z row: unit(xf cross yf).
  rmo_pkg::wvec_t cz;
  rmo_pkg::vec3_t zf, xfd;
  logic okzf, ok4;

  rmo_cross u_cz (.clk(clk), .en(en), .a(xf), .b(yf), .c(cz));
  rmo_unit #(.W(64)) u_nzf (.clk(clk), .en(en), .v(cz), .u(zf), .ok(okzf));

  rmo_delay #(.W(97), .N(U + C)) u_d4 (
    .clk(clk), .en(en),
    .d({ok3d & okxf & okyf, xf}),
    .q({ok4, xfd})
  );

  // Final y row: z cross x, rounded half away from zero to Q2.30.
  rmo_pkg::wvec_t cy;
  rmo_pkg::vec3_t row1;
  logic [2:0][63:0] cymag;
  logic [2:0][63:0] cyq;

  rmo_cross u_cy (.clk(clk), .en(en), .a(zf), .b(xfd), .c(cy));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cymag[i] = cy[i][63] ? (~cy[i] + 64'd1) : cy[i];
      cyq[i]   = (cymag[i] + (64'd1 << (rmo_pkg::FRAC - 1))) >> rmo_pkg::FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        row1[i] <= cy[i][63] ? 32'(~cyq[i] + 64'd1) : cyq[i][31:0];
      end
    end
  end

  rmo_pkg::vec3_t zfo, xfo;
  logic           okf;

  rmo_delay #(.W(193), .N(C + 1)) u_d5 (
    .clk(clk), .en(en),
    .d({ok4 & okzf, zf, xfd}),
    .q({okf, zfo, xfo})
  );

  // The input item rides alongside for the degenerate case.
  logic [287:0] mdel;

  rmo_delay #(.W(288), .N(L)) u_dm (.clk(clk), .en(en), .d(s_axis_tdata), .q(mdel));

  // Output register.
  rmo_pkg::mat_t omat;
  logic          odeg;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      odeg <= !okf;
      if (okf) begin
        omat <= {zfo, row1, xfo};
      end else begin
        omat <= rmo_pkg::mat_t'(mdel);
      end
    end
  end

  assign m_axis_tdata = omat;
  assign m_axis_tuser = odeg;

endmodule
